// ===== rtl/core/latency_stats_histogram_median_top_macros.svh =====
// ----------------------------------------------------------------------------
// Latency statistics assertion macros
// Shared property forms for the checker; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef LATENCY_STATS_HISTOGRAM_MEDIAN_TOP_MACROS_SVH
`define LATENCY_STATS_HISTOGRAM_MEDIAN_TOP_MACROS_SVH

// same-cycle implication
`define LSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("latency stats check failed");

// next-cycle implication
`define LSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("latency stats check failed");

`endif

// ===== rtl/core/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// Types, constants and codes shared by the latency statistics block.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int LSM_WINDOW_DEPTH = 1024;
    localparam int LSM_NUM_BOUNDS   = 6;
    localparam int MAX_BOUNDS       = 6;
    localparam int RTT_W            = 23;
    localparam int CNT_W            = 32;
    localparam int SUM_W            = 64;
    localparam int LOSS_W           = 17;
    localparam int CFG_IDX_W        = 3;
    localparam int FRAC_W           = 16;

    localparam logic [RTT_W-1:0] BOUND_RST [MAX_BOUNDS] = '{
        23'd10000, 23'd20000, 23'd50000, 23'd100000, 23'd200000, 23'd500000
    };

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BUCKET  = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_SNAPSHOT = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_LOSS_GO,
        S_LOSS_WAIT,
        S_MED_GO,
        S_MED_WAIT,
        S_EMIT
    } t_state;

    // window control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic clr;
        logic start;
    } t_win_ctl;

endpackage

// ===== rtl/core/lsm_div.sv =====
// ----------------------------------------------------------------------------
// lsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsm_div
    import lsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot
);

    localparam int CW = $clog2(SUM_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   r_rem;
    logic [SUM_W-1:0] r_quot;
    logic [CNT_W-1:0] r_dvsr;
    logic [CNT_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem[CNT_W-1:0], r_quot[SUM_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SUM_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvsr <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_sh - {1'b0, r_dvsr}) : w_sh;
                r_quot <= {r_quot[SUM_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/lsm_win.sv =====
// ----------------------------------------------------------------------------
// lsm_win
// Sliding window memory and radix-select median engine over its one read port.
// ----------------------------------------------------------------------------
module lsm_win
    import lsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = LSM_WINDOW_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_win_ctl         i_ctl,
    input  logic [RTT_W-1:0] i_wr_data,
    output logic             o_done,
    output logic [RTT_W-1:0] o_median
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int BW = $clog2(RTT_W);

    logic [RTT_W-1:0] r_mem [WINDOW_DEPTH];
    logic [RTT_W-1:0] r_rd_data;
    logic [AW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_addr;
    logic             r_run, r_issue, r_dv, r_dlast, r_done;
    logic [BW-1:0]    r_bit;
    logic [RTT_W-1:0] r_pa, r_pb, r_med;
    logic [FW-1:0]    r_ka, r_kb, r_ca, r_cb;

    logic [RTT_W-1:0] w_one_sh, w_mask, w_bit1;
    logic             w_ma, w_mb, w_ba, w_bb;
    logic [FW-1:0]    w_fa, w_fb;
    logic [RTT_W-1:0] w_pa, w_pb;
    logic [RTT_W:0]   w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[r_head] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_addr[AW-1:0]];
    end

    // compare against the decided upper bits, count zeros at the current bit
    assign w_one_sh = RTT_W'(1) << (r_bit + 1'b1);
    assign w_mask   = ~(w_one_sh - RTT_W'(1));
    assign w_bit1   = RTT_W'(1) << r_bit;
    assign w_ma = (((r_rd_data ^ r_pa) & w_mask) == '0) && !r_rd_data[r_bit];
    assign w_mb = (((r_rd_data ^ r_pb) & w_mask) == '0) && !r_rd_data[r_bit];
    assign w_fa = r_ca + FW'(w_ma);
    assign w_fb = r_cb + FW'(w_mb);
    assign w_ba = !(r_ka < w_fa);
    assign w_bb = !(r_kb < w_fb);
    assign w_pa = w_ba ? (r_pa | w_bit1) : r_pa;
    assign w_pb = w_bb ? (r_pb | w_bit1) : r_pb;
    assign w_sum = {1'b0, w_pa} + {1'b0, w_pb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_run   <= 1'b0;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.clr) begin
                r_head <= '0;
                r_fill <= '0;
            end else if (i_ctl.wr_en) begin
                r_head <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
                if (r_fill != FW'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_issue <= 1'b1;
                r_dv    <= 1'b0;
                r_addr  <= '0;
                r_bit   <= BW'(RTT_W - 1);
                r_pa    <= '0;
                r_pb    <= '0;
                r_ka    <= (r_fill - 1'b1) >> 1;
                r_kb    <= r_fill >> 1;
                r_ca    <= '0;
                r_cb    <= '0;
            end else if (r_run) begin
                r_dv    <= r_issue;
                r_dlast <= r_issue && (r_addr == r_fill - 1'b1);
                if (r_issue) begin
                    if (r_addr == r_fill - 1'b1) begin
                        r_issue <= 1'b0;
                    end
                    r_addr <= r_addr + 1'b1;
                end
                if (r_dv && !r_dlast) begin
                    r_ca <= w_fa;
                    r_cb <= w_fb;
                end
                if (r_dv && r_dlast) begin
                    // close this bit: fix both prefixes, rank into the upper half
                    r_pa <= w_pa;
                    r_pb <= w_pb;
                    if (w_ba) r_ka <= r_ka - w_fa;
                    if (w_bb) r_kb <= r_kb - w_fb;
                    r_ca <= '0;
                    r_cb <= '0;
                    if (r_bit == '0) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                        r_med  <= w_sum[RTT_W:1];
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_issue <= 1'b1;
                        r_addr  <= '0;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_median = r_med;

endmodule

// ===== rtl/core/latency_stats_histogram_median_top.sv =====
// ----------------------------------------------------------------------------
// latency_stats_histogram_median_top
// Round-trip latency statistics: counters, histogram, window median.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_op, i_rtt_us, i_success
//  out     | output    | o_out_valid / i_out_ready| o_kind .. o_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  Sample and clear requests produce no result.
//  Snapshot runs the mean and loss divisions, then, when there were
//  successes, the median selection, one read-port pass per result bit,
//  then NUM_BOUNDS+2 results, one per output handshake.
//  Reset is synchronous, active low; the window needs no clearing pass.
//  In ready is low from a snapshot until its last result is taken.
// ----------------------------------------------------------------------------
module latency_stats_histogram_median_top
    import lsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = LSM_WINDOW_DEPTH,
    parameter int NUM_BOUNDS   = LSM_NUM_BOUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic signed [23:0]   i_rtt_us,
    input  logic                 i_success,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [CNT_W-1:0]     o_sent_total,
    output logic [LOSS_W-1:0]    o_loss_q16,
    output logic [RTT_W-1:0]     o_min_us,
    output logic [RTT_W-1:0]     o_max_us,
    output logic [RTT_W-1:0]     o_mean_us,
    output logic [RTT_W-1:0]     o_median_us,
    output logic [RTT_W-1:0]     o_bucket_bound_us,
    output logic [CNT_W-1:0]     o_bucket_count,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RTT_W-1:0]     i_cfg_data
);

    localparam int NB  = NUM_BOUNDS + 1;
    localparam int BKW = $clog2(NB);
    localparam int IW  = $clog2(NUM_BOUNDS + 2);
    localparam int BIW = $clog2(MAX_BOUNDS);

    t_state           r_state, n_state;
    logic [RTT_W-1:0] r_bound [MAX_BOUNDS];
    logic [CNT_W-1:0] r_sent, r_succ;
    logic [RTT_W-1:0] r_min, r_max, r_mean;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_bucket [NB];
    logic [LOSS_W-1:0] r_loss;
    logic [IW-1:0]    r_idx;

    logic             w_in_acc, w_out_acc, w_snap, w_sample, w_clear;
    logic [RTT_W-1:0] w_rtt;
    logic [SUM_W:0]   w_sum;
    logic [BKW-1:0]   w_bkt;
    logic             w_div_start, w_div_done;
    logic [SUM_W-1:0] w_dividend, w_quot;
    logic [CNT_W-1:0] w_divisor, w_lost;
    t_win_ctl         w_win;
    logic             w_win_done;
    logic [RTT_W-1:0] w_median;
    logic [BKW-1:0]   w_oi;
    logic [BIW-1:0]   w_bi;
    logic             w_is_last;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_sample  = w_in_acc && (t_op'(i_op) == OP_SAMPLE);
    assign w_snap    = w_in_acc && (t_op'(i_op) == OP_SNAPSHOT);
    assign w_clear   = w_in_acc && (t_op'(i_op) == OP_CLEAR);
    assign o_cfg_ready = 1'b1;

    // clamp negative round trips to zero
    assign w_rtt = i_rtt_us[23] ? '0 : i_rtt_us[RTT_W-1:0];
    assign w_sum = {1'b0, r_sum} + (SUM_W + 1)'(w_rtt);

    // first bound above the sample wins, else the overflow bucket
    always_comb begin
        w_bkt = BKW'(NUM_BOUNDS);
        for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
            if (w_rtt < r_bound[i]) begin
                w_bkt = BKW'(i);
            end
        end
    end

    assign w_lost = r_sent - r_succ;

    always_comb begin
        w_dividend = r_sum;
        w_divisor  = r_succ;
        if (r_state == S_LOSS_GO) begin
            w_dividend = {{(SUM_W - CNT_W - FRAC_W){1'b0}}, w_lost, {FRAC_W{1'b0}}};
            w_divisor  = r_sent;
        end
    end

    lsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    lsm_win #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_win),
        .i_wr_data (w_rtt),
        .o_done    (w_win_done),
        .o_median  (w_median)
    );

    assign w_is_last = (r_idx == IW'(NUM_BOUNDS + 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_snap) n_state = S_MEAN_GO;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: if (w_div_done) n_state = S_LOSS_GO;
            S_LOSS_GO:   n_state = S_LOSS_WAIT;
            S_LOSS_WAIT: begin
                if (w_div_done) n_state = (r_succ != '0) ? S_MED_GO : S_EMIT;
            end
            S_MED_GO:    n_state = S_MED_WAIT;
            S_MED_WAIT:  if (w_win_done) n_state = S_EMIT;
            S_EMIT:      if (w_out_acc && w_is_last) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_EMIT);
        w_div_start = (r_state == S_MEAN_GO) || (r_state == S_LOSS_GO);
        w_win.start = (r_state == S_MED_GO);
        w_win.wr_en = w_sample && i_success;
        w_win.clr   = w_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < MAX_BOUNDS; i++) r_bound[i] <= BOUND_RST[i];
            r_sent <= '0;
            r_succ <= '0;
            r_min  <= '1;
            r_max  <= '0;
            r_sum  <= '0;
            for (int i = 0; i < NB; i++) r_bucket[i] <= '0;
            r_idx  <= '0;
        end else begin
            r_state <= n_state;
            // writes beyond the bound list drop
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index < CFG_IDX_W'(MAX_BOUNDS))) begin
                r_bound[i_cfg_index] <= i_cfg_data;
            end
            if (w_clear) begin
                r_sent <= '0;
                r_succ <= '0;
                r_min  <= '1;
                r_max  <= '0;
                r_sum  <= '0;
                for (int i = 0; i < NB; i++) r_bucket[i] <= '0;
            end
            if (w_sample) begin
                if (r_sent != '1) r_sent <= r_sent + 1'b1;
                if (i_success) begin
                    if (r_succ != '1) r_succ <= r_succ + 1'b1;
                    r_sum <= w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
                    if (w_rtt < r_min) r_min <= w_rtt;
                    if (w_rtt > r_max) r_max <= w_rtt;
                    if (r_bucket[w_bkt] != '1) r_bucket[w_bkt] <= r_bucket[w_bkt] + 1'b1;
                end
            end
            if (w_snap) r_idx <= '0;
            if (w_out_acc) r_idx <= r_idx + 1'b1;
        end
    end

    // hold the divider results for the summary
    always_ff @(posedge i_clk) begin
        if (r_state == S_MEAN_WAIT && w_div_done) begin
            r_mean <= (w_quot[SUM_W-1:RTT_W] != '0) ? '1 : w_quot[RTT_W-1:0];
        end
        if (r_state == S_LOSS_WAIT && w_div_done) begin
            r_loss <= w_quot[LOSS_W-1:0];
        end
    end

    assign w_oi = BKW'(r_idx - 1'b1);
    assign w_bi = (r_idx - 1'b1 < IW'(NUM_BOUNDS)) ? BIW'(r_idx - 1'b1)
                                                  : BIW'(NUM_BOUNDS - 1);

    // result payload: summary first, then one bucket per result
    always_comb begin
        o_kind            = KIND_SUMMARY;
        o_sent_total      = '0;
        o_loss_q16        = '0;
        o_min_us          = '0;
        o_max_us          = '0;
        o_mean_us         = '0;
        o_median_us       = '0;
        o_bucket_bound_us = '0;
        o_bucket_count    = '0;
        o_last            = 1'b0;
        if (r_idx == '0) begin
            o_sent_total = r_sent;
            if (r_sent != '0) o_loss_q16 = r_loss;
            if (r_succ != '0) begin
                o_min_us    = r_min;
                o_max_us    = r_max;
                o_mean_us   = r_mean;
                o_median_us = w_median;
            end
        end else begin
            o_kind            = KIND_BUCKET;
            o_bucket_bound_us = r_bound[w_bi];
            o_bucket_count    = r_bucket[w_oi];
            o_last            = w_is_last;
        end
    end

endmodule

// ===== rtl/core/lsm_chk.sv =====
// ----------------------------------------------------------------------------
// lsm_chk
// Port-level checks for the latency statistics block, bound to the top.
// ----------------------------------------------------------------------------
`include "latency_stats_histogram_median_top_macros.svh"

module lsm_chk
    import lsm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_kind,
    input logic o_last
);

    `LSM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `LSM_ASSERT_IMP(a_no_overlap, o_out_valid, !o_in_ready)
    `LSM_ASSERT_NXT(a_last_ends, o_out_valid && i_out_ready && o_last, !o_out_valid)
    `LSM_ASSERT_IMP(a_summary_not_last, o_out_valid && (o_kind == KIND_SUMMARY), !o_last)

endmodule

bind latency_stats_histogram_median_top lsm_chk u_lsm_chk (.*);
